[hw/rtl/cfur_pkg.sv]
// shared types, constants and crc function for the framed serial receiver
// no dependencies; imported by cfur_parser, cfur_obuf and crc_framed_uart_receiver
`default_nettype none

package cfur_pkg;

    // frame geometry
    localparam int MaxPayload   = 16;
    localparam int LenWidth     = 5;
    localparam int IdxWidth     = 5;
    localparam int StoreAddrW   = $clog2(MaxPayload);

    // crc16/modbus
    localparam logic [15:0] CrcInit = 16'hFFFF;
    localparam logic [15:0] CrcPoly = 16'hA001;

    // configuration register indexes
    localparam logic [1:0] CfgHeaderFirst  = 2'd0;
    localparam logic [1:0] CfgHeaderSecond = 2'd1;
    localparam logic [1:0] CfgMinPayload   = 2'd2;

    // reset values of configuration registers
    localparam logic [7:0]          HeaderFirstRst  = 8'hAA;
    localparam logic [7:0]          HeaderSecondRst = 8'h55;
    localparam logic [LenWidth-1:0] MinPayloadRst   = 5'd4;
    localparam logic [LenWidth-1:0] MinPayloadFloor = 5'd2;

    typedef enum logic [1:0] {
        PH_HUNT1 = 2'd0,
        PH_HUNT2 = 2'd1,
        PH_LEN   = 2'd2,
        PH_DATA  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_CRC_BAD  = 2'd1,
        ST_SHORT    = 2'd2
    } frame_status_t;

    // result word, last-listed field in the lowest bits
    typedef struct packed {
        logic [LenWidth-1:0] payload_length;
        logic [7:0]          heartbeat_byte;
        logic signed [15:0]  speed_value;
        logic [1:0]          frame_status;
    } result_t;

    // one byte through the reflected crc16, bit by bit
    function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
                                                 input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CrcPoly;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/crc_framed_uart_receiver.sv]
// Framed serial byte receiver with CRC16/MODBUS check.
// Input stream s_*: one received byte per transaction (s_tdata). Output
// stream m_*: one result per completed frame, m_tdata fields from bit 0 up:
// frame_status[1:0], speed_value[17:2], heartbeat_byte[25:18],
// payload_length[30:26], bit 31 zero.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 first
// header byte, 1 second header byte, 2 minimum payload length); write only
// while no frame result is outstanding.
// Throughput: one byte per cycle while s_tready is high. A byte goes into
// the input register, is parsed once the result buffer has room, and its
// result (on the last CRC byte) is written into the output register, or into
// the skid entry when the output register is occupied. The header/length/crc
// step of the parser is combinational between input register and buffer.
// Reset clears the parser to header hunt, restores register defaults and
// empties both buffers. When m_tready is low, results fill the output register
// and a skid entry; only when both are full does s_tready drop, so bytes keep
// flowing while a single result waits.
// depends on cfur_pkg, cfur_parser, cfur_obuf
`default_nettype none

module crc_framed_uart_receiver (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte[7:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // status, speed, heartbeat, length, pad
);
    import cfur_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       advance;
    logic       buf_full;
    logic       res_valid;
    result_t    res_data;
    result_t    out_data;

    // input register advances whenever the result buffer has room
    assign advance       = in_valid_reg && !buf_full;
    assign s_tready      = !in_valid_reg || !buf_full;
    assign in_valid_next = (s_tvalid && s_tready) || (in_valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_byte_reg <= s_tdata;
    end

    cfur_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .byte_valid (advance),
        .byte_data  (in_byte_reg),
        .res_valid  (res_valid),
        .res_data   (res_data)
    );

    cfur_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res_data),
        .full      (buf_full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {1'b0, out_data};

endmodule

`default_nettype wire

[hw/rtl/cfur_parser.sv]
// frame parser: header hunt, length check, crc accumulation, payload store
// and final status decision; depends on cfur_pkg
`default_nettype none

module cfur_parser (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [7:0]        cfg_data,
    input  wire logic              byte_valid,
    input  wire logic [7:0]        byte_data,
    output logic                   res_valid,
    output cfur_pkg::result_t      res_data
);
    import cfur_pkg::*;

    logic [7:0]            header_first_reg;
    logic [7:0]            header_second_reg;
    logic [LenWidth-1:0]   min_len_reg;

    phase_t                phase_reg, phase_next;
    logic [LenWidth-1:0]   frame_len_reg, frame_len_next;
    logic [IdxWidth-1:0]   byte_index_reg, byte_index_next;
    logic [15:0]           crc_reg, crc_next;
    logic [7:0]            prev_byte_reg;
    logic [7:0]            store_reg [MaxPayload];

    logic [IdxWidth:0]     index_inc;
    logic [IdxWidth:0]     frame_end;
    logic [15:0]           crc_recv;
    logic [LenWidth-1:0]   eff_min;
    logic [LenWidth-1:0]   heart_idx;
    logic                  store_we;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_first_reg  <= HeaderFirstRst;
            header_second_reg <= HeaderSecondRst;
            min_len_reg       <= MinPayloadRst;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CfgHeaderFirst:  header_first_reg  <= cfg_data;
                CfgHeaderSecond: header_second_reg <= cfg_data;
                CfgMinPayload:   min_len_reg       <= cfg_data[LenWidth-1:0];
                default:         ;
            endcase
        end
    end

    // end-of-frame helpers
    assign index_inc = {1'b0, byte_index_reg} + 1'b1;
    assign frame_end = {1'b0, frame_len_reg} + 2'd2;
    assign crc_recv  = {byte_data, prev_byte_reg};
    assign eff_min   = (min_len_reg < MinPayloadFloor) ? MinPayloadFloor : min_len_reg;
    assign heart_idx = eff_min - 1'b1;
    assign store_we  = byte_valid && (phase_reg == PH_DATA)
                       && (byte_index_reg < IdxWidth'(MaxPayload));

    // next state and result
    always_comb
    begin
        phase_next      = phase_reg;
        frame_len_next  = frame_len_reg;
        byte_index_next = byte_index_reg;
        crc_next        = crc_reg;
        res_valid       = 1'b0;
        res_data        = '0;
        res_data.payload_length = frame_len_reg;
        if (byte_valid)
        begin
            unique case (phase_reg)
                PH_HUNT1:
                begin
                    if (byte_data == header_first_reg)
                        phase_next = PH_HUNT2;
                end
                PH_HUNT2:
                begin
                    priority if (byte_data == header_second_reg)
                        phase_next = PH_LEN;
                    else if (byte_data == header_first_reg)
                        phase_next = PH_HUNT2;
                    else
                        phase_next = PH_HUNT1;
                end
                PH_LEN:
                begin
                    if (byte_data > 8'(MaxPayload))
                        phase_next = PH_HUNT1;
                    else
                    begin
                        frame_len_next  = byte_data[LenWidth-1:0];
                        byte_index_next = '0;
                        crc_next        = crc16_update(CrcInit, byte_data);
                        phase_next      = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    if (byte_index_reg < frame_len_reg)
                        crc_next = crc16_update(crc_reg, byte_data);
                    byte_index_next = index_inc[IdxWidth-1:0];
                    if (index_inc >= frame_end)
                    begin
                        // crc bytes are always the last two of the frame
                        res_valid  = 1'b1;
                        phase_next = PH_HUNT1;
                        priority if (crc_recv != crc_reg)
                            res_data.frame_status = ST_CRC_BAD;
                        else if (frame_len_reg < eff_min)
                            res_data.frame_status = ST_SHORT;
                        else
                        begin
                            res_data.frame_status   = ST_ACCEPTED;
                            res_data.speed_value    = {store_reg[1], store_reg[0]};
                            res_data.heartbeat_byte = store_reg[heart_idx[StoreAddrW-1:0]];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT1;
            frame_len_reg  <= '0;
            byte_index_reg <= '0;
            crc_reg        <= CrcInit;
        end
        else
        begin
            phase_reg      <= phase_next;
            frame_len_reg  <= frame_len_next;
            byte_index_reg <= byte_index_next;
            crc_reg        <= crc_next;
        end
    end

    // payload store and previous byte
    always_ff @(posedge clk)
    begin
        if (byte_valid)
            prev_byte_reg <= byte_data;
        if (store_we)
            store_reg[byte_index_reg[StoreAddrW-1:0]] <= byte_data;
    end

endmodule

`default_nettype wire

[hw/rtl/cfur_obuf.sv]
// two-entry result buffer: output register plus skid entry
// depends on cfur_pkg
`default_nettype none

module cfur_obuf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire cfur_pkg::result_t push_data,
    output logic                   full,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output cfur_pkg::result_t      out_data
);
    import cfur_pkg::*;

    logic    head_valid_reg, head_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t head_reg, head_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign pop       = head_valid_reg && out_ready;
    assign full      = skid_valid_reg;
    assign out_valid = head_valid_reg;
    assign out_data  = head_reg;

    // entry movement
    always_comb
    begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                head_next = skid_reg;
                if (push)
                    skid_next = push_data;
                else
                    skid_valid_next = 1'b0;
            end
            else if (push)
                head_next = push_data;
            else
                head_valid_next = 1'b0;
        end
        else if (push)
        begin
            if (!head_valid_reg)
            begin
                head_next       = push_data;
                head_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire
